/* hw/rtl/ecu_pkg.sv */
// ecu_pkg: constants, types, lookup tables and helper functions for the easing curve unit.
// The tables are computed at elaboration by the constant functions below.
// No dependencies.
package ecu_pkg;

    localparam int FRAC_BITS = 16;
    localparam int TAB_AW    = 8;
    localparam int TAB_N     = 1 << TAB_AW;
    localparam int PROG_W    = FRAC_BITS + 1;
    localparam int EASED_W   = 19;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int NSTG      = 12;
    localparam int SQ_STEPS  = 6;
    localparam int EXP_ZERO_Q = 62;

    localparam logic [PROG_W-1:0] FX_ONE  = PROG_W'(1) << FRAC_BITS;
    localparam logic [PROG_W-1:0] FX_HALF = PROG_W'(1) << (FRAC_BITS - 1);

    localparam logic signed [30:0] EASED_MAX = 31'sd262143;
    localparam logic signed [30:0] EASED_MIN = -31'sd262144;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;

    // curve codes
    localparam logic [2:0] KIND_POWER = 3'd0;
    localparam logic [2:0] KIND_SINE  = 3'd1;
    localparam logic [2:0] KIND_ROOT  = 3'd2;
    localparam logic [2:0] KIND_OVER  = 3'd3;
    localparam logic [2:0] KIND_SPRING = 3'd4;
    localparam logic [2:0] KIND_BOUNCE = 3'd5;
    localparam logic [2:0] KIND_ACCEL = 3'd6;

    // direction codes
    localparam logic [1:0] DIR_IN   = 2'd0;
    localparam logic [1:0] DIR_OUT  = 2'd1;
    localparam logic [1:0] DIR_BOTH = 2'd2;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_KIND  = 3'd0;
    localparam logic [2:0] REG_DIR   = 3'd1;
    localparam logic [2:0] REG_POWER = 3'd2;
    localparam logic [2:0] REG_FREQ  = 3'd3;
    localparam logic [2:0] REG_OVER  = 3'd4;

    localparam logic [15:0] RST_POWER = 16'd512;
    localparam logic [15:0] RST_FREQ  = 16'd256;
    localparam logic [15:0] RST_OVER  = 16'd435;

    typedef logic [31:0] t_tab [0:TAB_N];

    // one table read: base sample, slope to next sample, fraction between them
    typedef struct packed {
        logic [31:0]        t0;
        logic signed [32:0] diff;
        logic [TAB_AW-1:0]  frac;
    } t_lk;

    // digit-by-digit square root state
    typedef struct packed {
        logic [19:0] rem;
        logic [17:0] root;
        logic [35:0] rad;
    } t_sq;

    // long division by shift and subtract, elaboration only
    function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= d) begin
                r = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic t_tab mk_sin();
        t_tab tb;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] n;
        logic signed [63:0] sum;
        logic neg;
        for (int k = 0; k <= TAB_N; k++) begin
            x = (HALF_PI_Q30 * 64'(k)) >> TAB_AW;
            x2 = (x * x) >> 30;
            t = x;
            sum = $signed(x);
            neg = 1'b1;
            for (n = 64'd2; t != 0 && n < 64'd40; n = n + 64'd2) begin
                t = udiv((t * x2) >> 30, n * (n + 64'd1));
                sum = neg ? sum - $signed(t) : sum + $signed(t);
                neg = !neg;
            end
            tb[k] = sum[31:0];
        end
        return tb;
    endfunction

    function automatic t_tab mk_exp();
        t_tab tb;
        logic [63:0] y;
        logic [63:0] e;
        logic [63:0] et;
        logic [63:0] n;
        for (int k = 0; k <= TAB_N; k++) begin
            y = (LN2_Q30 * 64'(k)) >> TAB_AW;
            e = 64'd1 << 30;
            et = e;
            for (n = 64'd1; et != 0 && n < 64'd40; n = n + 64'd1) begin
                et = udiv((et * y) >> 30, n);
                e = e + et;
            end
            tb[k] = e[31:0];
        end
        return tb;
    endfunction

    function automatic t_tab mk_log();
        t_tab tb;
        logic [63:0] m;
        logic [63:0] r;
        for (int k = 0; k <= TAB_N; k++) begin
            if (k == TAB_N) begin
                tb[k] = 32'd1 << 30;
            end else begin
                m = (64'd1 << 30) + (64'(k) << (30 - TAB_AW));
                r = '0;
                for (int i = 1; i <= 30; i++) begin
                    m = (m * m) >> 30;
                    if (m >= (64'd2 << 30)) begin
                        m = m >> 1;
                        r = r | (64'd1 << (30 - i));
                    end
                end
                tb[k] = r[31:0];
            end
        end
        return tb;
    endfunction

    localparam t_tab SIN_TAB = mk_sin();
    localparam t_tab EXP_TAB = mk_exp();
    localparam t_tab LOG_TAB = mk_log();

    // first half of a table lookup at x in [0, 1]
    function automatic t_lk lk_rd(input t_tab tab, input logic [PROG_W-1:0] x);
        t_lk l;
        logic [TAB_AW:0] ix;
        ix = {1'b0, x[FRAC_BITS-1 -: TAB_AW]};
        if (x[FRAC_BITS]) begin
            l.t0 = tab[TAB_N];
            l.diff = '0;
            l.frac = '0;
        end else begin
            l.t0 = tab[ix];
            l.diff = $signed({1'b0, tab[ix + 1'b1]}) - $signed({1'b0, tab[ix]});
            l.frac = x[FRAC_BITS-TAB_AW-1:0];
        end
        return l;
    endfunction

    // interpolate and round the Q30 sample to Q16
    function automatic logic [17:0] lk_fin(input t_lk l);
        logic signed [42:0] prod;
        logic signed [42:0] val;
        prod = l.diff * $signed({1'b0, l.frac});
        val = $signed({11'b0, l.t0}) + (prod >>> (FRAC_BITS - TAB_AW))
              + (43'sd1 <<< (29 - FRAC_BITS));
        return val[(30-FRAC_BITS) +: 18];
    endfunction

    function automatic t_sq sq_steps(input t_sq s);
        t_sq o;
        logic [21:0] rem2;
        logic [21:0] trial;
        o = s;
        for (int i = 0; i < SQ_STEPS; i++) begin
            rem2 = {o.rem, o.rad[35:34]};
            trial = {2'b00, o.root, 2'b01};
            o.rad = {o.rad[33:0], 2'b00};
            if (rem2 >= trial) begin
                o.rem = 20'(rem2 - trial);
                o.root = {o.root[16:0], 1'b1};
            end else begin
                o.rem = rem2[19:0];
                o.root = {o.root[16:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage

/* hw/rtl/easing_curve_unit.sv */
// easing_curve_unit: maps a progress word to its eased value by one of seven curves.
// Twelve register stages. Takes one word per cycle while the output is not stalled;
// each stage holds its word until the next stage frees, and bubbles close up under stall.
// Stages: direction fold, table reads, interpolation multiplies, log/exp power, then a
// three-stage square root (six digits per stage) and output saturation.
// Reset (synchronous, active low) clears all valid bits and loads register defaults.
module easing_curve_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ecu_pkg::PADDR_W-1:0]   paddr,
    input  logic [ecu_pkg::PDATA_W-1:0]   pwdata,
    output logic [ecu_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ecu_pkg::PROG_W-1:0]    i_progress,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [ecu_pkg::EASED_W-1:0] o_eased,
    output logic                          o_saturated
);
    import ecu_pkg::*;

    logic [2:0]  r_kind;
    logic [1:0]  r_dir;
    logic [15:0] r_pow;
    logic [15:0] r_freq;
    logic [15:0] r_over;

    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   w_en;

    // stage 0
    logic [16:0] n_p, n_mir, n_s0_v;
    logic        n_s0_hi;
    logic [16:0] r_s0_v;
    logic        r_s0_hi;
    // stage 1
    logic [4:0]  n_e;
    logic [32:0] n_sh;
    logic [35:0] n_usp_prod;
    logic [34:0] n_ubn_prod;
    logic [33:0] n_vv;
    logic [33:0] n_lin;
    logic signed [34:0] n_ldiff;
    logic [32:0] n_by_prod;
    logic [16:0] r_s1_v;
    logic        r_s1_hi, r_s1_pz, r_s1_pone;
    logic [4:0]  r_s1_e;
    logic [15:0] r_s1_mf;
    logic [17:0] r_s1_usp, r_s1_ubn;
    logic [16:0] r_s1_v2;
    logic signed [26:0] r_s1_inner;
    logic [24:0] r_s1_by;
    // stage 2
    logic [16:0] n_xsp, n_xbn;
    logic [16:0] r_s2_v;
    logic        r_s2_hi, r_s2_pz, r_s2_pone;
    logic [4:0]  r_s2_e;
    t_lk         r_s2_lg, r_s2_sp, r_s2_bn, r_s2_sv, r_s2_e2;
    logic        r_s2_spneg, r_s2_bbig, r_s2_br0;
    logic [5:0]  r_s2_bq;
    logic [16:0] r_s2_v2;
    logic signed [26:0] r_s2_inner;
    // stage 3
    logic signed [44:0] n_ov_prod;
    logic [16:0] r_s3_v;
    logic        r_s3_hi, r_s3_pz, r_s3_pone;
    logic [4:0]  r_s3_e;
    logic [17:0] r_s3_l, r_s3_spm, r_s3_bnm, r_s3_sinv, r_s3_e2raw;
    logic        r_s3_spneg, r_s3_bbig, r_s3_br0;
    logic [5:0]  r_s3_bq;
    logic signed [28:0] r_s3_ov;
    // stage 4
    logic [20:0] n_mag;
    logic [36:0] n_y_prod;
    logic [17:0] n_e2b;
    logic [16:0] r_s4_v;
    logic        r_s4_hi, r_s4_pz, r_s4_pone;
    logic [28:0] r_s4_y;
    logic signed [18:0] r_s4_ssp;
    logic [17:0] r_s4_bnm, r_s4_sinv;
    logic [16:0] r_s4_e2b;
    logic signed [28:0] r_s4_ov;
    // stage 5
    logic [34:0] n_bnc_prod;
    logic [16:0] r_s5_v;
    logic        r_s5_hi, r_s5_pz, r_s5_pone, r_s5_big, r_s5_r0;
    logic [5:0]  r_s5_q;
    t_lk         r_s5_ex;
    logic signed [18:0] r_s5_ssp;
    logic [17:0] r_s5_sinv;
    logic [18:0] r_s5_bnc;
    logic signed [28:0] r_s5_ov;
    // stage 6
    logic [17:0] n_pow;
    logic [16:0] r_s6_v;
    logic        r_s6_hi;
    logic [16:0] r_s6_pow;
    logic signed [18:0] r_s6_ssp;
    logic [17:0] r_s6_sinv;
    logic [18:0] r_s6_bnc;
    logic signed [28:0] r_s6_ov;
    // stage 7
    logic signed [36:0] n_spr_prod;
    logic [33:0] n_acc_prod;
    logic [18:0] n_acc;
    logic signed [28:0] n_coth;
    logic [16:0] n_w;
    logic        r_s7_hi, r_s7_usq;
    logic signed [28:0] r_s7_coth;
    logic [32:0] r_s7_a;
    // stages 8..10: square root
    logic        r_s8_hi, r_s8_usq, r_s9_hi, r_s9_usq, r_s10_hi, r_s10_usq;
    logic signed [28:0] r_s8_coth, r_s9_coth, r_s10_coth;
    t_sq         r_s8_sq, r_s9_sq, r_s10_sq;
    // output stage
    logic signed [30:0] n_c, n_r;
    logic signed [EASED_W-1:0] n_eased;
    logic        n_sat;
    logic signed [EASED_W-1:0] r_out_eased;
    logic        r_out_sat;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_POWER;
            r_dir  <= DIR_IN;
            r_pow  <= RST_POWER;
            r_freq <= RST_FREQ;
            r_over <= RST_OVER;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[PADDR_W-1:2])
                REG_KIND:  r_kind <= pwdata[2:0];
                REG_DIR:   r_dir  <= pwdata[1:0];
                REG_POWER: r_pow  <= pwdata[15:0];
                REG_FREQ:  r_freq <= pwdata[15:0];
                REG_OVER:  r_over <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_KIND:  prdata = {29'b0, r_kind};
            REG_DIR:   prdata = {30'b0, r_dir};
            REG_POWER: prdata = {16'b0, r_pow};
            REG_FREQ:  prdata = {16'b0, r_freq};
            REG_OVER:  prdata = {16'b0, r_over};
            default:   prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    always_comb begin
        w_en[NSTG] = i_out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_eased     = r_out_eased;
    assign o_saturated = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_in_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---------------- combinational stage logic ----------------
    always_comb begin
        // clamp and fold by direction
        n_p = (i_progress > FX_ONE) ? FX_ONE : i_progress;
        n_mir = FX_ONE - n_p;
        n_s0_v = n_p;
        n_s0_hi = 1'b0;
        case (r_dir)
            DIR_OUT: n_s0_v = n_mir;
            DIR_BOTH: begin
                if (n_p < FX_HALF) begin
                    n_s0_v = {n_p[15:0], 1'b0};
                end else begin
                    n_s0_v = {n_mir[15:0], 1'b0};
                    n_s0_hi = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        // normalize v to m in [1,2): e = left shift count
        n_e = 5'd16;
        for (int b = 0; b < FRAC_BITS; b++) begin
            if (r_s0_v[b]) n_e = 5'(FRAC_BITS - b);
        end
        n_sh = {16'b0, r_s0_v} << n_e;
        n_usp_prod = r_s0_v * ({1'b0, r_freq, 2'b00} + 19'd256);
        n_ubn_prod = r_s0_v * ({1'b0, r_freq, 1'b0} + 18'd256);
        n_vv = r_s0_v * r_s0_v;
        n_lin = r_s0_v * ({1'b0, r_over} + 17'd256);
        n_ldiff = $signed({1'b0, n_lin}) - $signed({3'b0, r_over, 16'b0});
        n_by_prod = r_pow * (FX_ONE - r_s0_v);
    end

    always_comb begin
        // quadrant fold of the sine arguments
        n_xsp = r_s1_usp[16] ? FX_ONE - {1'b0, r_s1_usp[15:0]} : {1'b0, r_s1_usp[15:0]};
        n_xbn = r_s1_ubn[16] ? FX_ONE - {1'b0, r_s1_ubn[15:0]} : {1'b0, r_s1_ubn[15:0]};
    end

    assign n_ov_prod = $signed({1'b0, r_s2_v2}) * r_s2_inner;

    always_comb begin
        n_mag = {r_s3_e, 16'b0} - {3'b0, r_s3_l};
        n_y_prod = n_mag * r_pow;
        if (r_s3_bbig) begin
            n_e2b = '0;
        end else if (r_s3_br0) begin
            n_e2b = {1'b0, FX_ONE} >> r_s3_bq;
        end else begin
            n_e2b = r_s3_e2raw >> ({1'b0, r_s3_bq} + 7'd1);
        end
    end

    assign n_bnc_prod = r_s4_e2b * r_s4_bnm;

    always_comb begin
        if (r_s5_pone) begin
            n_pow = {1'b0, FX_ONE};
        end else if (r_s5_pz) begin
            n_pow = (r_pow == '0) ? {1'b0, FX_ONE} : '0;
        end else if (r_s5_big) begin
            n_pow = '0;
        end else if (r_s5_r0) begin
            n_pow = {1'b0, FX_ONE} >> r_s5_q;
        end else begin
            n_pow = lk_fin(r_s5_ex) >> ({1'b0, r_s5_q} + 7'd1);
        end
    end

    always_comb begin
        n_spr_prod = $signed({1'b0, r_s6_pow}) * r_s6_ssp;
        n_acc_prod = r_s6_pow * (FX_ONE - r_s6_v);
        n_acc = {2'b0, r_s6_v} + {1'b0, n_acc_prod[33:16]};
        n_w = FX_ONE - r_s6_pow;
        case (r_kind)
            KIND_POWER:  n_coth = $signed({12'b0, r_s6_pow});
            KIND_SINE:   n_coth = $signed({11'b0, r_s6_sinv});
            KIND_OVER:   n_coth = r_s6_ov;
            KIND_SPRING: n_coth = 29'($signed(n_spr_prod[36:16]));
            KIND_BOUNCE: n_coth = $signed({10'b0, r_s6_bnc});
            KIND_ACCEL:  n_coth = $signed({10'b0, n_acc});
            default:     n_coth = $signed({12'b0, r_s6_v});
        endcase
    end

    always_comb begin
        n_c = r_s10_usq ? $signed({14'b0, FX_ONE - r_s10_sq.root[16:0]}) : 31'(r_s10_coth);
        n_r = n_c;
        case (r_dir)
            DIR_OUT:  n_r = $signed({14'b0, FX_ONE}) - n_c;
            DIR_BOTH: begin
                if (r_s10_hi) begin
                    n_r = (($signed({14'b0, FX_ONE}) - n_c) >>> 1) + $signed({14'b0, FX_HALF});
                end else begin
                    n_r = n_c >>> 1;
                end
            end
            default: ;
        endcase
        n_sat = 1'b0;
        n_eased = n_r[EASED_W-1:0];
        if (n_r > EASED_MAX) begin
            n_sat = 1'b1;
            n_eased = EASED_MAX[EASED_W-1:0];
        end else if (n_r < EASED_MIN) begin
            n_sat = 1'b1;
            n_eased = EASED_MIN[EASED_W-1:0];
        end
    end

    // ---------------- stage registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_v  <= n_s0_v;
            r_s0_hi <= n_s0_hi;
        end
        if (w_en[1]) begin
            r_s1_v     <= r_s0_v;
            r_s1_hi    <= r_s0_hi;
            r_s1_pz    <= (r_s0_v == '0);
            r_s1_pone  <= r_s0_v[FRAC_BITS];
            r_s1_e     <= n_e;
            r_s1_mf    <= n_sh[15:0];
            r_s1_usp   <= n_usp_prod[25:8];
            r_s1_ubn   <= n_ubn_prod[25:8];
            r_s1_v2    <= n_vv[32:16];
            r_s1_inner <= n_ldiff[34:8];
            r_s1_by    <= n_by_prod[32:8];
        end
        if (w_en[2]) begin
            r_s2_v     <= r_s1_v;
            r_s2_hi    <= r_s1_hi;
            r_s2_pz    <= r_s1_pz;
            r_s2_pone  <= r_s1_pone;
            r_s2_e     <= r_s1_e;
            r_s2_lg    <= lk_rd(LOG_TAB, {1'b0, r_s1_mf});
            r_s2_sp    <= lk_rd(SIN_TAB, n_xsp);
            r_s2_spneg <= r_s1_usp[17];
            r_s2_bn    <= lk_rd(SIN_TAB, n_xbn);
            r_s2_sv    <= lk_rd(SIN_TAB, r_s1_v);
            r_s2_e2    <= lk_rd(EXP_TAB, FX_ONE - {1'b0, r_s1_by[15:0]});
            r_s2_bbig  <= (r_s1_by[24:16] >= 9'(EXP_ZERO_Q));
            r_s2_br0   <= (r_s1_by[15:0] == '0);
            r_s2_bq    <= r_s1_by[21:16];
            r_s2_v2    <= r_s1_v2;
            r_s2_inner <= r_s1_inner;
        end
        if (w_en[3]) begin
            r_s3_v     <= r_s2_v;
            r_s3_hi    <= r_s2_hi;
            r_s3_pz    <= r_s2_pz;
            r_s3_pone  <= r_s2_pone;
            r_s3_e     <= r_s2_e;
            r_s3_l     <= lk_fin(r_s2_lg);
            r_s3_spm   <= lk_fin(r_s2_sp);
            r_s3_spneg <= r_s2_spneg;
            r_s3_bnm   <= lk_fin(r_s2_bn);
            r_s3_sinv  <= lk_fin(r_s2_sv);
            r_s3_e2raw <= lk_fin(r_s2_e2);
            r_s3_bbig  <= r_s2_bbig;
            r_s3_br0   <= r_s2_br0;
            r_s3_bq    <= r_s2_bq;
            r_s3_ov    <= n_ov_prod[44:16];
        end
        if (w_en[4]) begin
            r_s4_v    <= r_s3_v;
            r_s4_hi   <= r_s3_hi;
            r_s4_pz   <= r_s3_pz;
            r_s4_pone <= r_s3_pone;
            r_s4_y    <= n_y_prod[36:8];
            r_s4_ssp  <= r_s3_spneg ? -$signed({1'b0, r_s3_spm}) : $signed({1'b0, r_s3_spm});
            r_s4_bnm  <= r_s3_bnm;
            r_s4_sinv <= r_s3_sinv;
            r_s4_e2b  <= n_e2b[16:0];
            r_s4_ov   <= r_s3_ov;
        end
        if (w_en[5]) begin
            r_s5_v    <= r_s4_v;
            r_s5_hi   <= r_s4_hi;
            r_s5_pz   <= r_s4_pz;
            r_s5_pone <= r_s4_pone;
            r_s5_big  <= (r_s4_y[28:16] >= 13'(EXP_ZERO_Q));
            r_s5_r0   <= (r_s4_y[15:0] == '0);
            r_s5_q    <= r_s4_y[21:16];
            r_s5_ex   <= lk_rd(EXP_TAB, FX_ONE - {1'b0, r_s4_y[15:0]});
            r_s5_ssp  <= r_s4_ssp;
            r_s5_sinv <= r_s4_sinv;
            r_s5_bnc  <= n_bnc_prod[34:16];
            r_s5_ov   <= r_s4_ov;
        end
        if (w_en[6]) begin
            r_s6_v    <= r_s5_v;
            r_s6_hi   <= r_s5_hi;
            r_s6_pow  <= n_pow[16:0];
            r_s6_ssp  <= r_s5_ssp;
            r_s6_sinv <= r_s5_sinv;
            r_s6_bnc  <= r_s5_bnc;
            r_s6_ov   <= r_s5_ov;
        end
        if (w_en[7]) begin
            r_s7_hi   <= r_s6_hi;
            r_s7_coth <= n_coth;
            // root is the identity at both ends of the range
            r_s7_usq  <= (r_kind == KIND_ROOT) && (r_s6_v != '0) && !r_s6_v[FRAC_BITS];
            r_s7_a    <= {n_w, 16'b0};
        end
        if (w_en[8]) begin
            r_s8_hi   <= r_s7_hi;
            r_s8_usq  <= r_s7_usq;
            r_s8_coth <= r_s7_coth;
            r_s8_sq   <= sq_steps('{rem: '0, root: '0, rad: {3'b0, r_s7_a}});
        end
        if (w_en[9]) begin
            r_s9_hi   <= r_s8_hi;
            r_s9_usq  <= r_s8_usq;
            r_s9_coth <= r_s8_coth;
            r_s9_sq   <= sq_steps(r_s8_sq);
        end
        if (w_en[10]) begin
            r_s10_hi   <= r_s9_hi;
            r_s10_usq  <= r_s9_usq;
            r_s10_coth <= r_s9_coth;
            r_s10_sq   <= sq_steps(r_s9_sq);
        end
        if (w_en[11]) begin
            r_out_eased <= n_eased;
            r_out_sat   <= n_sat;
        end
    end

    // ---------------- assertions ----------------
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |->
            (o_eased == EASED_MAX[EASED_W-1:0]) || (o_eased == EASED_MIN[EASED_W-1:0]))
        else $error("saturated word not at a rail");

    a_pow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> r_s6_pow <= FX_ONE)
        else $error("power term above one");

    a_root_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] && r_s7_usq |-> r_kind == KIND_ROOT)
        else $error("square root path used outside root curve");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[10] && r_s10_usq |-> r_s10_sq.root <= 18'(FX_ONE))
        else $error("square root above one");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && !o_in_ready |=> $stable(r_vld))
        else $error("full pipeline changed while stalled");

endmodule

/* dv/tb_easing_curve_unit.sv */
// tb_easing_curve_unit: self-checking testbench for the easing curve unit.
// Drives progress words and APB register writes, predicts each eased word in a scoreboard.
// Depends on ecu_pkg and easing_curve_unit.
module tb_easing_curve_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ecu_pkg::*;

    typedef longint t_samples [0:256];

    typedef struct {
        logic signed [EASED_W-1:0] eased;
        logic                      sat;
    } t_eased_word;

    class easing_scoreboard;
        t_samples sin_s, log_s, exp_s;
        longint unsigned kind, dir, pwr, freq, over;
        t_eased_word pending[$];
        int errors;
        int checked;

        function new();
            longint unsigned x, x2, t, y, e, et, m, r, n;
            longint sum;
            bit neg;
            for (int k = 0; k <= 256; k++) begin
                x = 64'd1686629713 * k / 256;
                x2 = (x * x) >> 30;
                t = x;
                sum = x;
                neg = 1;
                for (n = 2; t != 0 && n < 40; n += 2) begin
                    t = ((t * x2) >> 30) / (n * (n + 1));
                    sum = neg ? sum - longint'(t) : sum + longint'(t);
                    neg = !neg;
                end
                sin_s[k] = sum;
                y = 64'd744261118 * k / 256;
                e = 64'd1 << 30;
                et = e;
                for (n = 1; et != 0 && n < 40; n++) begin
                    et = ((et * y) >> 30) / n;
                    e += et;
                end
                exp_s[k] = e;
                if (k == 256) begin
                    log_s[k] = 64'd1 << 30;
                end else begin
                    m = (64'd1 << 30) + ((longint'(k) << 30) / 256);
                    r = 0;
                    for (int i = 1; i <= 30; i++) begin
                        m = (m * m) >> 30;
                        if (m >= (64'd2 << 30)) begin
                            m >>= 1;
                            r |= 64'd1 << (30 - i);
                        end
                    end
                    log_s[k] = r;
                end
            end
            kind = 0; dir = 0; pwr = 512; freq = 256; over = 435;
            errors = 0;
            checked = 0;
        endfunction

        function longint interp(t_samples tab, longint x);
            longint pos, idx, val;
            if (x < 0) x = 0;
            if (x > 65536) x = 65536;
            pos = x * 256;
            idx = pos >>> 16;
            if (idx >= 256) val = tab[256];
            else val = tab[idx] + (((tab[idx+1] - tab[idx]) * (pos & 65535)) >>> 16);
            return (val + (64'sd1 <<< 13)) >>> 14;
        endfunction

        function longint pow2_neg(longint y);
            longint q, r;
            q = y >>> 16;
            r = y & 65535;
            if (q >= 62) return 0;
            if (r == 0) return 64'sd65536 >>> q;
            return interp(exp_s, 65536 - r) >>> (q + 1);
        endfunction

        function longint raise(longint v, longint p);
            longint m, e;
            if (v <= 0) return p == 0 ? 65536 : 0;
            if (v >= 65536) return 65536;
            m = v;
            e = 0;
            while (m < 65536) begin
                m <<= 1;
                e++;
            end
            return pow2_neg(((e * 65536 - interp(log_s, m - 65536)) * p) >>> 8);
        endfunction

        function longint sine_turns(longint u);
            longint q, r;
            q = (u >>> 16) & 3;
            r = u & 65535;
            case (q)
                0: return interp(sin_s, r);
                1: return interp(sin_s, 65536 - r);
                2: return -interp(sin_s, r);
                default: return -interp(sin_s, 65536 - r);
            endcase
        endfunction

        function longint floor_sqrt(longint unsigned a);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > a) b >>= 2;
            while (b != 0) begin
                if (a >= res + b) begin
                    a -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        function longint shape(longint v);
            longint p, f, o, s;
            p = pwr; f = freq; o = over;
            case (kind[2:0])
                KIND_POWER: return raise(v, p);
                KIND_SINE: return interp(sin_s, v);
                KIND_ROOT: begin
                    if (v <= 0 || v >= 65536) return v;
                    return 65536 - floor_sqrt((65536 - raise(v, p)) << 16);
                end
                KIND_OVER: return (((v * v) >>> 16) * (((256 + o) * v - o * 65536) >>> 8)) >>> 16;
                KIND_SPRING: begin
                    s = sine_turns((v * (4 * f + 256)) >>> 8);
                    return (raise(v, p) * s) >>> 16;
                end
                KIND_BOUNCE: begin
                    s = sine_turns((v * (2 * f + 256)) >>> 8);
                    if (s < 0) s = -s;
                    return (pow2_neg((p * (65536 - v)) >>> 8) * s) >>> 16;
                end
                KIND_ACCEL: return v + ((raise(v, p) * (65536 - v)) >>> 16);
                default: return v;
            endcase
        endfunction

        function void note_progress(logic [PROG_W-1:0] prog);
            longint v, r;
            t_eased_word w;
            v = prog > 65536 ? 65536 : prog;
            if (dir[1:0] == DIR_OUT) r = 65536 - shape(65536 - v);
            else if (dir[1:0] == DIR_BOTH) begin
                if (v < 32768) r = shape(2 * v) >>> 1;
                else r = ((65536 - shape(131072 - 2 * v)) >>> 1) + 32768;
            end else r = shape(v);
            w.sat = 0;
            if (r > 262143) begin r = 262143; w.sat = 1; end
            if (r < -262144) begin r = -262144; w.sat = 1; end
            w.eased = r[EASED_W-1:0];
            pending.push_back(w);
        endfunction

        function void check_word(logic signed [EASED_W-1:0] eased, logic sat);
            t_eased_word w;
            checked++;
            if (pending.size() == 0) begin
                $error("eased word with nothing pending: %0d", eased);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (eased !== w.eased) begin
                $error("eased: expected %0d, got %0d", w.eased, eased);
                errors++;
            end
            if (sat !== w.sat) begin
                $error("saturated: expected %0d, got %0d", w.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;
    logic i_in_valid = 0;
    logic o_in_ready;
    logic [PROG_W-1:0] i_progress = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    logic signed [EASED_W-1:0] o_eased;
    logic o_saturated;

    easing_curve_unit dut (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    easing_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;
    int words_sent = 0;
    int phases_run = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_word(o_eased, o_saturated);
    end

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("tb_easing_curve_unit: done, errors");
            $finish;
        end
    end

    task automatic send_progress(logic [PROG_W-1:0] prog);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_progress <= prog;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_progress(prog);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= PADDR_W'(idx) << 2;
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        case (idx)
            REG_KIND:  sb.kind = val[2:0];
            REG_DIR:   sb.dir = val[1:0];
            REG_POWER: sb.pwr = val;
            REG_FREQ:  sb.freq = val;
            default:   sb.over = val;
        endcase
    endtask

    function automatic logic [15:0] pick_q88();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1280));
        endcase
    endfunction

    function automatic logic [PROG_W-1:0] pick_progress();
        case ($urandom_range(9))
            0: return PROG_W'($urandom_range(65537, 131071));
            1: return PROG_W'($urandom_range(3) == 0 ? 0 : 65536);
            default: return PROG_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic config_phase(int kind, int dir, logic [15:0] p, logic [15:0] f,
                                logic [15:0] o);
        drain();
        write_reg(REG_KIND, 16'(kind));
        write_reg(REG_DIR, 16'(dir));
        write_reg(REG_POWER, p);
        write_reg(REG_FREQ, f);
        write_reg(REG_OVER, o);
        phases_run++;
    endtask

    localparam logic [PROG_W-1:0] EDGE_VALS [10] = '{0, 1, 2, 32767, 32768, 32769,
                                                     65535, 65536, 65537, 131071};

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // reset settings first, then the unused kind and direction codes, then the overshoot curve
        foreach (EDGE_VALS[i]) send_progress(EDGE_VALS[i]);
        config_phase(7, 3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        foreach (EDGE_VALS[i]) send_progress(EDGE_VALS[i]);
        config_phase(KIND_OVER, DIR_IN, 16'd0, 16'd0, 16'hFFFF);
        foreach (EDGE_VALS[i]) send_progress(EDGE_VALS[i]);

        for (int ph = 0; ph < 24; ph++) begin
            send_idle_pct = ph < 8 ? 23 : (ph < 16 ? 49 : 0);
            recv_idle_pct = ph < 8 ? 49 : (ph < 16 ? 23 : 0);
            config_phase(ph < 8 ? ph : $urandom_range(7), $urandom_range(3),
                         pick_q88(), pick_q88(), pick_q88());
            if (ph == 18) hold_cycles = 300;
            for (int k = 0; k < 34; k++) send_progress(pick_progress());
        end
        drain();
        $display("covered %0d words over %0d register settings, all curves and directions",
                 words_sent, phases_run);
        $display("%0d eased words checked, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_easing_curve_unit: done, clean");
        else
            $display("tb_easing_curve_unit: done, errors");
        $finish;
    end
endmodule
